>>> rtl/core/sliding_window_replay_filter_unit_assert.svh
// Assertion macros used by the replay filter RTL.
`ifndef SLIDING_WINDOW_REPLAY_FILTER_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_REPLAY_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define SWRF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define SWRF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SWRF_ASSERT_IMP(label, ante, cons, msg)

`define SWRF_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/core/swrf_pkg.sv
// Package with the constants and types of the replay filter.
package swrf_pkg;

    localparam int unsigned CTR_W       = 64;
    localparam int unsigned WORD_BITS   = 64;
    localparam int unsigned RING_WORDS  = 128;
    localparam int unsigned WINDOW_SIZE = 8128;

    localparam int unsigned BIT_W  = $clog2(WORD_BITS);
    localparam int unsigned SLOT_W = $clog2(RING_WORDS);
    localparam int unsigned WIDX_W = CTR_W - BIT_W;

    typedef enum logic [1:0] {
        REASON_OK     = 2'd0,
        REASON_LIMIT  = 2'd1,
        REASON_BEHIND = 2'd2,
        REASON_DUP    = 2'd3
    } reason_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

endpackage

>>> rtl/core/swrf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module swrf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/sliding_window_replay_filter_unit.sv
// Sliding-window anti-replay filter with a ring bitmap held in RAM.
//
//  Channel   Handshake                 Payload
//  input     in_valid / in_stall       packet_counter[63:0]
//  result    out_valid / out_stall     accept, reject_reason[1:0]
//  config    cfg_wr_en                 cfg_wr_data[63:0] (reject limit)
//
// Each transaction passes four states: accept, check, bitmap read, bitmap write.
// The bitmap RAM read latency and its read-modify-write set the pace.
// Reset clears the highest counter and the per-word valid flags at once; no sweep.
// A further transaction is taken while the previous result waits at the output,
// but the write-back waits until that result has been taken.
module sliding_window_replay_filter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] packet_counter,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accept,
    output logic [1:0]  reject_reason,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data
);

`include "sliding_window_replay_filter_unit_assert.svh"

    localparam int unsigned CTR_W      = swrf_pkg::CTR_W;
    localparam int unsigned WORD_BITS  = swrf_pkg::WORD_BITS;
    localparam int unsigned RING_WORDS = swrf_pkg::RING_WORDS;
    localparam int unsigned BIT_W      = swrf_pkg::BIT_W;
    localparam int unsigned SLOT_W     = swrf_pkg::SLOT_W;
    localparam int unsigned WIDX_W     = swrf_pkg::WIDX_W;

    swrf_pkg::state_t       state_reg, state_next;

    logic [CTR_W-1:0]       limit_reg, limit_next;
    logic [CTR_W-1:0]       highest_reg, highest_next;
    logic [RING_WORDS-1:0]  valid_reg, valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   accept_reg, accept_next;
    swrf_pkg::reason_t      reason_reg, reason_next;

    logic [CTR_W-1:0]       ctr_reg, ctr_next;
    logic                   over_reg, over_next;
    logic                   adv_reg, adv_next;
    logic [CTR_W-1:0]       diff_reg, diff_next;
    logic                   clear_all_reg, clear_all_next;
    logic [SLOT_W-1:0]      span_reg, span_next;
    logic [SLOT_W-1:0]      start_reg, start_next;
    logic                   pass_reg, pass_next;
    swrf_pkg::reason_t      early_reason_reg, early_reason_next;

    logic [WIDX_W-1:0]      span_full;
    logic [SLOT_W-1:0]      slot;
    logic [BIT_W-1:0]       bit_pos;
    logic [WORD_BITS-1:0]   bit_onehot;
    logic [WORD_BITS-1:0]   rdata;
    logic [WORD_BITS-1:0]   old_word;
    logic                   out_free;
    logic                   behind;
    logic                   ram_re;
    logic                   ram_we;
    logic [SLOT_W-1:0]      offset;

    assign slot       = ctr_reg[BIT_W +: SLOT_W];
    assign bit_pos    = ctr_reg[BIT_W-1:0];
    assign bit_onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_pos;
    assign span_full  = ctr_reg[CTR_W-1:BIT_W] - highest_reg[CTR_W-1:BIT_W];
    assign out_free   = !out_valid_reg || !out_stall;
    assign behind     = !adv_reg && (diff_reg > CTR_W'(swrf_pkg::WINDOW_SIZE));
    assign old_word   = valid_reg[slot] ? rdata : '0;
    assign ram_re     = (state_reg == swrf_pkg::ST_LOOKUP);
    assign ram_we     = (state_reg == swrf_pkg::ST_UPDATE) && out_free && pass_reg;

    assign in_stall      = (state_reg != swrf_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign accept        = accept_reg;
    assign reject_reason = reason_reg;

    swrf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (RING_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (old_word | bit_onehot),
        .re    (ram_re),
        .raddr (slot),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swrf_pkg::ST_IDLE;
            limit_reg     <= '1;
            highest_reg   <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            highest_reg   <= highest_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctr_reg          <= ctr_next;
        over_reg         <= over_next;
        adv_reg          <= adv_next;
        diff_reg         <= diff_next;
        clear_all_reg    <= clear_all_next;
        span_reg         <= span_next;
        start_reg        <= start_next;
        pass_reg         <= pass_next;
        early_reason_reg <= early_reason_next;
        accept_reg       <= accept_next;
        reason_reg       <= reason_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        limit_next        = cfg_wr_en ? cfg_wr_data : limit_reg;
        highest_next      = highest_reg;
        valid_next        = valid_reg;
        out_valid_next    = out_valid_reg && out_stall;
        accept_next       = accept_reg;
        reason_next       = reason_reg;
        ctr_next          = ctr_reg;
        over_next         = over_reg;
        adv_next          = adv_reg;
        diff_next         = diff_reg;
        clear_all_next    = clear_all_reg;
        span_next         = span_reg;
        start_next        = start_reg;
        pass_next         = pass_reg;
        early_reason_next = early_reason_reg;
        offset            = '0;

        unique case (state_reg)
            swrf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctr_next   = packet_counter;
                    state_next = swrf_pkg::ST_CHECK;
                end
            end
            swrf_pkg::ST_CHECK:
            begin
                over_next      = ctr_reg >= limit_reg;
                adv_next       = ctr_reg > highest_reg;
                diff_next      = highest_reg - ctr_reg;
                clear_all_next = span_full >= WIDX_W'(RING_WORDS);
                span_next      = span_full[SLOT_W-1:0];
                start_next     = highest_reg[BIT_W +: SLOT_W] + SLOT_W'(1);
                state_next     = swrf_pkg::ST_LOOKUP;
            end
            swrf_pkg::ST_LOOKUP:
            begin
                pass_next = !over_reg && !behind;
                early_reason_next = over_reg ? swrf_pkg::REASON_LIMIT
                                             : swrf_pkg::REASON_BEHIND;
                if (!over_reg && adv_reg)
                begin
                    highest_next = ctr_reg;
                    for (int s = 0; s < int'(RING_WORDS); s++)
                    begin
                        offset = SLOT_W'(s) - start_reg;
                        if (clear_all_reg || (offset < span_reg))
                        begin
                            valid_next[SLOT_W'(s)] = 1'b0;
                        end
                    end
                end
                state_next = swrf_pkg::ST_UPDATE;
            end
            swrf_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (pass_reg)
                    begin
                        valid_next[slot] = 1'b1;
                        if (old_word[bit_pos])
                        begin
                            accept_next = 1'b0;
                            reason_next = swrf_pkg::REASON_DUP;
                        end
                        else
                        begin
                            accept_next = 1'b1;
                            reason_next = swrf_pkg::REASON_OK;
                        end
                    end
                    else
                    begin
                        accept_next = 1'b0;
                        reason_next = early_reason_reg;
                    end
                    state_next = swrf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swrf_pkg::ST_IDLE;
            end
        endcase
    end

    `SWRF_ASSERT_IMP(a_accept_matches_reason, out_valid_reg,
        accept_reg == (reason_reg == swrf_pkg::REASON_OK),
        "accept flag disagrees with the reject reason")

    `SWRF_ASSERT_NXT(a_highest_monotonic, 1'b1,
        highest_reg >= $past(highest_reg),
        "highest counter moved backwards")

    `SWRF_ASSERT_NXT(a_written_word_valid, ram_we,
        valid_reg[$past(slot)],
        "bitmap word written but not marked valid")

endmodule

>>> verif/sliding_window_replay_filter_unit_tb.sv
// Self-checking testbench for the sliding-window replay filter unit.
module sliding_window_replay_filter_unit_tb;

    localparam int unsigned CTR_W       = swrf_pkg::CTR_W;
    localparam int unsigned WORD_BITS   = swrf_pkg::WORD_BITS;
    localparam int unsigned RING_WORDS  = swrf_pkg::RING_WORDS;
    localparam int unsigned WINDOW_SIZE = swrf_pkg::WINDOW_SIZE;
    localparam int unsigned BIT_W       = swrf_pkg::BIT_W;
    localparam int unsigned SLOT_W      = swrf_pkg::SLOT_W;
    localparam int unsigned WIDX_W      = swrf_pkg::WIDX_W;

    typedef struct packed {
        logic              accept;
        swrf_pkg::reason_t reason;
    } verdict_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [CTR_W-1:0] packet_counter;
    logic             out_valid;
    logic             out_stall;
    logic             accept;
    logic [1:0]       reject_reason;
    logic             cfg_wr_en;
    logic [CTR_W-1:0] cfg_wr_data;

    logic [CTR_W-1:0]     limit_model;
    logic [CTR_W-1:0]     highest_model;
    logic [WORD_BITS-1:0] ring_model [RING_WORDS];

    verdict_t         pending_verdicts [$];
    logic [CTR_W-1:0] recent_counters [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int results_seen;
    int limit_writes;
    int reason_tally [4];

    sliding_window_replay_filter_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .packet_counter(packet_counter),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .accept        (accept),
        .reject_reason (reject_reason),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic swrf_pkg::reason_t predict_verdict(input logic [CTR_W-1:0] ctr);
        logic [WIDX_W-1:0]    word_idx;
        logic [WIDX_W-1:0]    top_word;
        logic [WIDX_W-1:0]    span;
        logic [WORD_BITS-1:0] prior;
        logic [WORD_BITS-1:0] one_hot;
        logic [SLOT_W-1:0]    slot;
        logic [SLOT_W-1:0]    clr_slot;
        int                   k;
        if (ctr >= limit_model)
            return swrf_pkg::REASON_LIMIT;
        word_idx = ctr[CTR_W-1:BIT_W];
        if (ctr > highest_model)
        begin
            top_word = highest_model[CTR_W-1:BIT_W];
            span = word_idx - top_word;
            if (span > WIDX_W'(RING_WORDS))
                span = WIDX_W'(RING_WORDS);
            for (k = 1; k <= int'(span); k++)
            begin
                clr_slot = SLOT_W'(top_word + WIDX_W'(k));
                ring_model[clr_slot] = '0;
            end
            highest_model = ctr;
        end
        else if (highest_model - ctr > CTR_W'(WINDOW_SIZE))
        begin
            return swrf_pkg::REASON_BEHIND;
        end
        slot = word_idx[SLOT_W-1:0];
        one_hot = {{(WORD_BITS-1){1'b0}}, 1'b1} << ctr[BIT_W-1:0];
        prior = ring_model[slot];
        ring_model[slot] = prior | one_hot;
        return (ring_model[slot] != prior) ? swrf_pkg::REASON_OK : swrf_pkg::REASON_DUP;
    endfunction

    task automatic send_counter(input logic [CTR_W-1:0] ctr);
        verdict_t want;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            packet_counter <= {$urandom, $urandom};
            @(negedge clk);
        end
        in_valid <= 1'b1;
        packet_counter <= ctr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want.reason = predict_verdict(ctr);
        want.accept = (want.reason == swrf_pkg::REASON_OK);
        pending_verdicts.push_back(want);
        recent_counters.push_back(ctr);
        if (recent_counters.size() > 64)
            void'(recent_counters.pop_front());
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reject_limit(input logic [CTR_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= {$urandom, $urandom};
        limit_model = value;
        limit_writes++;
    endtask

    function automatic logic [CTR_W-1:0] pick_counter();
        logic [CTR_W-1:0] back;
        int               choice;
        choice = $urandom_range(99);
        if (choice < 30)
            return highest_model + CTR_W'($urandom_range(1, 300));
        if (choice < 55)
        begin
            back = CTR_W'($urandom_range(0, WINDOW_SIZE + 64));
            if (back > highest_model)
                back = highest_model;
            return highest_model - back;
        end
        if (choice < 65 && recent_counters.size() != 0)
            return recent_counters[$urandom_range(recent_counters.size() - 1)];
        if (choice < 73)
            return highest_model
                   + CTR_W'($urandom_range(WORD_BITS, WORD_BITS * (RING_WORDS + 4)));
        if (choice < 77)
        begin
            back = CTR_W'(WINDOW_SIZE + $urandom_range(0, 1));
            return (back > highest_model) ? highest_model : highest_model - back;
        end
        if (choice < 83)
            return limit_model + CTR_W'($urandom_range(0, 2)) - CTR_W'(1);
        if (choice < 86)
            return {$urandom, $urandom};
        return highest_model - ((highest_model < CTR_W'(130)) ? CTR_W'(0)
                                : CTR_W'($urandom_range(0, 130)));
    endfunction

    task automatic test_fresh_after_reset();
        send_counter(64'd0);
        send_counter(64'd0);
        send_counter(64'd1);
        send_counter(64'd1);
        send_counter(64'd63);
        send_counter(64'd64);
        send_counter(64'd200);
    endtask

    task automatic test_window_edges();
        send_counter(64'd10000);
        send_counter(64'd10000 - CTR_W'(WINDOW_SIZE));
        send_counter(64'd10000 - CTR_W'(WINDOW_SIZE) - 64'd1);
        send_counter(64'd10000);
        send_counter(64'd9999);
    endtask

    task automatic test_ring_clear();
        send_counter(64'd10000 + CTR_W'(WORD_BITS * RING_WORDS));
        send_counter(64'd10100);
        send_counter(64'd1 << 40);
        send_counter((64'd1 << 40) - 64'd100);
        send_counter((64'd1 << 40) - 64'd100);
    endtask

    task automatic test_reject_limit();
        write_reject_limit('0);
        send_counter(64'd0);
        send_counter(highest_model + 64'd1);
        send_counter('1);
        write_reject_limit(highest_model + 64'd3);
        send_counter(highest_model + 64'd1);
        send_counter(highest_model + 64'd1);
        send_counter(limit_model);
        send_counter(limit_model + 64'd1);
        write_reject_limit(64'd1);
        send_counter(64'd0);
        send_counter(64'd1);
        write_reject_limit('1);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        int n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (n = 0; n < count; n++)
        begin
            if (n == count / 2 || $urandom_range(199) == 0)
                drain_results();
            send_counter(pick_counter());
        end
    endtask

    task automatic test_counter_top();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_counter(64'hFFFF_FFFF_FFFF_FFFE);
        send_counter(64'hFFFF_FFFF_FFFF_FFFF);
        send_counter(64'hFFFF_FFFF_FFFF_FFFE);
        send_counter(64'hFFFF_FFFF_FFFF_FFFD);
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            reason_tally[reject_reason]++;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: accept=%0b reason=%0d",
                             accept, reject_reason);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (accept !== want.accept || reject_reason !== want.reason)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected accept=%0b reason=%0d, %s%0b reason=%0d",
                                 want.accept, want.reason, "got accept=",
                                 accept, reject_reason);
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        packet_counter = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        ring_model = '{default: '0};
        reason_tally = '{default: 0};
        highest_model = '0;
        limit_model = '1;
        mismatches = 0;
        results_seen = 0;
        limit_writes = 0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_fresh_after_reset();
        test_window_edges();
        test_ring_clear();
        test_reject_limit();
        test_random_traffic(600, 11, 85);
        write_reject_limit(highest_model + 64'd3000);
        test_random_traffic(600, 85, 11);
        write_reject_limit('1);
        test_random_traffic(550, 0, 0);
        test_counter_top();
        drain_results();
        repeat (20) @(posedge clk);

        $display("Run covered %0d results: %0d fresh, %0d over limit, %0d stale, %0d replays.",
                 results_seen, reason_tally[swrf_pkg::REASON_OK],
                 reason_tally[swrf_pkg::REASON_LIMIT],
                 reason_tally[swrf_pkg::REASON_BEHIND], reason_tally[swrf_pkg::REASON_DUP]);
        $display("The reject limit was rewritten %0d times under three stall profiles.",
                 limit_writes);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sliding_window_replay_filter_unit.f
+incdir+rtl/core
rtl/core/swrf_pkg.sv
rtl/core/swrf_ram.sv
rtl/core/sliding_window_replay_filter_unit.sv
verif/sliding_window_replay_filter_unit_tb.sv
